// ===== rtl/crc16_checked_command_packet_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Packet decoder assertion macros
// Concurrent check helpers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef CRC16_CHECKED_COMMAND_PACKET_DECODER_TOP_ASSERT_SVH
`define CRC16_CHECKED_COMMAND_PACKET_DECODER_TOP_ASSERT_SVH

// checked only while out of reset
`define CCPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CCPD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ccpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpd_pkg
// Types, constants and helper functions of the command packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpd_pkg;

	typedef logic [3:0] idx_t;

	localparam idx_t PKT_LEN     = 4'd12;
	localparam idx_t POS_HEADER  = 4'd0;
	localparam idx_t POS_MODE    = 4'd1;
	localparam idx_t POS_YAW     = 4'd2;
	localparam idx_t POS_YAW_END = 4'd5;
	localparam idx_t POS_PITCH   = 4'd6;
	localparam idx_t POS_PIT_END = 4'd9;
	localparam idx_t POS_CRC_LO  = 4'd10;

	localparam logic [7:0]  PKT_HEADER = 8'hA5;
	localparam logic [7:0]  MODE_AIM   = 8'h01;
	localparam logic [7:0]  MODE_FIRE  = 8'h02;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8408;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_TOO_SHORT  = 2'd1,
		ST_BAD_HEADER = 2'd2,
		ST_BAD_CRC    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FIRE_NONE     = 2'd0,
		FIRE_AUTO_AIM = 2'd1,
		FIRE_AUTO     = 2'd2
	} shot_mode_t;

	typedef enum logic [1:0] {
		TGT_NONE       = 2'd0,
		TGT_CONVERGING = 2'd1,
		TGT_READY      = 2'd2
	} target_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_transfer;
	} in_beat_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] yaw_bits;
		logic [31:0] pitch_bits;
		shot_mode_t  shot_mode;
		target_t     track_state;
	} out_beat_t;

	// reflected crc-16, one byte, lsb first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic shot_mode_t mode_to_fire(input logic [7:0] mode);
		shot_mode_t f;
		case (mode)
			MODE_FIRE: f = FIRE_AUTO;
			MODE_AIM:  f = FIRE_AUTO_AIM;
			default:   f = FIRE_NONE;
		endcase
		return f;
	endfunction

	function automatic target_t mode_to_target(input logic [7:0] mode);
		target_t t;
		case (mode)
			MODE_FIRE: t = TGT_READY;
			MODE_AIM:  t = TGT_CONVERGING;
			default:   t = TGT_NONE;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ccpd_if.sv =====
// ----------------------------------------------------------------------------
// ccpd_if
// Valid/ready channels for received bytes and for transfer status reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccpd_in_if
	import ccpd_pkg::*;
	();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ccpd_out_if
	import ccpd_pkg::*;
	();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/crc16_checked_command_packet_decoder_top.sv =====
// ----------------------------------------------------------------------------
// crc16_checked_command_packet_decoder_top
// Frames a 12-byte command packet out of a byte stream, checks header and
// crc-16, and reports one status per transfer with the held command values.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                      beat
//  bytes    in   rx_byte, end_of_transfer                     one received byte
//  report   out  status, yaw_bits, pitch_bits, shot_mode,     one per transfer
//                track_state
//
//  one byte per cycle while no end byte waits on a stalled report; the byte
//  crc update and framing are combinational between the input register and
//  the report register, which raises valid once the last byte of a transfer
//  leaves the input register. arst_n clears byte index, crc, header flag,
//  held values and both valid flags. a stalled report blocks only a waiting
//  end-of-transfer byte; other bytes keep flowing while the report is held.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_checked_command_packet_decoder_top
	import ccpd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	ccpd_in_if.sink     bytes,
	ccpd_out_if.source  report
);

	`include "crc16_checked_command_packet_decoder_top_assert.svh"

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// framing state
	idx_t        idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic        hdr_q, hdr_d;
	logic [15:0] crcrx_q, crcrx_d;
	logic [31:0] yaw_cap_q, yaw_cap_d;
	logic [31:0] pitch_cap_q, pitch_cap_d;
	logic [7:0]  mode_q, mode_d;

	// held command
	logic [31:0] held_yaw_q;
	logic [31:0] held_pitch_q;
	shot_mode_t  held_fire_q;
	target_t     held_tgt_q;

	logic        out_valid_q;
	out_beat_t   out_q;

	logic        advance;
	logic        finish;
	logic        accept_pkt;
	status_t     status_d;
	logic [1:0]  yaw_lane;
	logic [1:0]  pitch_lane;

	// an end byte may move on only if the report register is empty or being read
	assign advance = valid_s1 && (!eot_s1 || !out_valid_q || report.ready);
	assign finish  = advance && eot_s1;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data.rx_byte;
			eot_s1  <= bytes.data.end_of_transfer;
		end
	end

	assign yaw_lane   = 2'(idx_q - POS_YAW);
	assign pitch_lane = 2'(idx_q - POS_PITCH);

	always_comb begin
		idx_d       = idx_q;
		crc_d       = crc_q;
		hdr_d       = hdr_q;
		crcrx_d     = crcrx_q;
		yaw_cap_d   = yaw_cap_q;
		pitch_cap_d = pitch_cap_q;
		mode_d      = mode_q;
		if (idx_q < PKT_LEN) begin
			case (idx_q) inside
				POS_HEADER:             hdr_d = (byte_s1 == PKT_HEADER);
				POS_MODE:               mode_d = byte_s1;
				[POS_YAW:POS_YAW_END]:  yaw_cap_d[{yaw_lane, 3'b000} +: 8] = byte_s1;
				[POS_PITCH:POS_PIT_END]: pitch_cap_d[{pitch_lane, 3'b000} +: 8] = byte_s1;
				POS_CRC_LO:             crcrx_d[7:0] = byte_s1;
				default:                crcrx_d[15:8] = byte_s1;
			endcase
			if (idx_q < POS_CRC_LO) begin
				crc_d = crc_update(crc_q, byte_s1);
			end
			idx_d = idx_q + 4'd1;
		end
	end

	// length first, then header, then crc
	always_comb begin
		if (idx_d < PKT_LEN) begin
			status_d = ST_TOO_SHORT;
		end else if (!hdr_d) begin
			status_d = ST_BAD_HEADER;
		end else if (crc_d != crcrx_d) begin
			status_d = ST_BAD_CRC;
		end else begin
			status_d = ST_ACCEPTED;
		end
	end

	assign accept_pkt = finish && (status_d == ST_ACCEPTED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
			hdr_q <= 1'b0;
		end else if (finish) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
			hdr_q <= 1'b0;
		end else if (advance) begin
			idx_q <= idx_d;
			crc_q <= crc_d;
			hdr_q <= hdr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			crcrx_q     <= crcrx_d;
			yaw_cap_q   <= yaw_cap_d;
			pitch_cap_q <= pitch_cap_d;
			mode_q      <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_yaw_q   <= '0;
			held_pitch_q <= '0;
			held_fire_q  <= FIRE_NONE;
			held_tgt_q   <= TGT_NONE;
		end else if (accept_pkt) begin
			held_yaw_q   <= yaw_cap_d;
			held_pitch_q <= pitch_cap_d;
			held_fire_q  <= mode_to_fire(mode_d);
			held_tgt_q   <= mode_to_target(mode_d);
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.status      <= status_d;
			out_q.yaw_bits    <= accept_pkt ? yaw_cap_d : held_yaw_q;
			out_q.pitch_bits  <= accept_pkt ? pitch_cap_d : held_pitch_q;
			out_q.shot_mode   <= accept_pkt ? mode_to_fire(mode_d) : held_fire_q;
			out_q.track_state <= accept_pkt ? mode_to_target(mode_d) : held_tgt_q;
		end
	end

	assign report.valid = out_valid_q;
	assign report.data  = out_q;

	`CCPD_ASSERT_ALWAYS(a_idx_saturates, idx_q <= PKT_LEN, "byte index beyond packet length")
	`CCPD_ASSERT(a_restart_after_end, finish |=> (idx_q == '0 && crc_q == CRC_INIT && !hdr_q),
		"framing not restarted after transfer end")
	`CCPD_ASSERT(a_held_only_on_accept, !accept_pkt |=> ($stable(held_yaw_q) && $stable(held_pitch_q)),
		"held command changed without an accepted packet")
	`CCPD_ASSERT(a_no_report_overwrite, (out_valid_q && !report.ready) |-> !finish,
		"pending report overwritten")
	`CCPD_ASSERT(a_ready_when_empty, !valid_s1 |-> bytes.ready, "input stalled with empty stage")

endmodule

`default_nettype wire
